>>> sv/bounded_int_stack_with_search_macros.svh
// assertion macros for the bounded integer stack
// used by bounded_int_stack_with_search; expects signals clock and reset in scope
`ifndef BOUNDED_INT_STACK_WITH_SEARCH_MACROS_SVH
`define BOUNDED_INT_STACK_WITH_SEARCH_MACROS_SVH

// same-cycle implication, disabled during reset
`define BIS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BIS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bis_pkg.sv
// types and codes shared by the bounded integer stack modules
// no dependencies
`timescale 1ns / 1ps

package bis_pkg;

   localparam int WORD_W  = 32;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;
   localparam int FIDX_W  = 6;
   localparam int CNT_O_W = 7;
   localparam int CAP_W   = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic signed [WORD_W-1:0] value;
   } bis_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [WORD_W-1:0] data;
      logic [FIDX_W-1:0]        found_index;
      logic [CNT_O_W-1:0]       count;
      logic                     is_empty;
      logic                     is_full;
   } bis_rsp_type;

endpackage

>>> sv/bis_ram.sv
// entry storage for the bounded integer stack: one write port, one registered read port
// depends on bis_pkg
`timescale 1ns / 1ps

module bis_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [bis_pkg::WORD_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [bis_pkg::WORD_W-1:0]  rd_data
);

   logic [bis_pkg::WORD_W-1:0] mem [DEPTH];
   logic [bis_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bis_seq.sv
// sequencer for the bounded integer stack: stack pointer, search walk and the key comparator
// depends on bis_pkg; drives bis_ram through its address and enable ports
`timescale 1ns / 1ps

module bis_seq #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int CW    = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_take,
   input  bis_pkg::bis_req_type              req_item,
   input  logic [bis_pkg::CAP_W-1:0]         capacity,
   output logic                              seq_idle,
   output logic                              res_load,
   output bis_pkg::bis_rsp_type              res_item,
   output logic                              wr_en,
   output logic [AW-1:0]                     wr_addr,
   output logic [bis_pkg::WORD_W-1:0]        wr_data,
   output logic                              rd_en,
   output logic [AW-1:0]                     rd_addr,
   input  logic [bis_pkg::WORD_W-1:0]        rd_data
);

   localparam int CMPW = (CW > bis_pkg::CAP_W) ? CW : bis_pkg::CAP_W;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              count_m1;
   logic [AW-1:0]              idx_ff, idx_in;
   logic [bis_pkg::WORD_W-1:0] key_ff, key_in;
   logic [CMPW-1:0]            cap_ext, depth_ext, eff_cap;
   logic [bis_pkg::STAT_W-1:0] status;
   logic [bis_pkg::WORD_W-1:0] data;
   logic [AW-1:0]              found;
   logic                       full_now;

   // capacity above the built depth acts as the depth
   assign cap_ext   = CMPW'(capacity);
   assign depth_ext = CMPW'(DEPTH);
   assign eff_cap   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
   assign full_now  = (CMPW'(count_ff) >= eff_cap);
   assign count_m1  = count_ff - CW'(1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[AW-1:0];
      wr_data  = req_item.value;
      rd_en    = 1'b0;
      rd_addr  = count_m1[AW-1:0];
      res_load = 1'b0;
      status   = bis_pkg::ST_OK;
      data     = '0;
      found    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_item.operation)
                  bis_pkg::OP_PUSH: begin
                     res_load = 1'b1;
                     if (full_now) begin
                        status = bis_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  bis_pkg::OP_POP, bis_pkg::OP_PEEK: begin
                     if (count_ff == '0) begin
                        status   = bis_pkg::ST_EMPTY;
                        res_load = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_READ;
                        if (req_item.operation == bis_pkg::OP_POP) begin
                           count_in = count_m1;
                        end
                     end
                  end
                  bis_pkg::OP_CLEAR: begin
                     count_in = '0;
                     res_load = 1'b1;
                  end
                  bis_pkg::OP_SEARCH: begin
                     if (count_ff == '0) begin
                        status   = bis_pkg::ST_NOTFOUND;
                        res_load = 1'b1;
                     end else begin
                        // walk starts at the top entry
                        rd_en    = 1'b1;
                        idx_in   = count_m1[AW-1:0];
                        key_in   = req_item.value;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     res_load = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            data     = rd_data;
            res_load = 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            // rd_data holds the entry at idx_ff
            if (rd_data == key_ff) begin
               found    = idx_ff;
               res_load = 1'b1;
               state_in = S_IDLE;
            end else if (idx_ff == '0) begin
               status   = bis_pkg::ST_NOTFOUND;
               res_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in  = idx_ff - AW'(1);
               rd_en   = 1'b1;
               rd_addr = idx_ff - AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      res_item.status      = status;
      res_item.data        = data;
      res_item.found_index = bis_pkg::FIDX_W'(found);
      res_item.count       = bis_pkg::CNT_O_W'(count_in);
      res_item.is_empty    = (count_in == '0);
      res_item.is_full     = (CMPW'(count_in) >= eff_cap);
   end

   assign seq_idle = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      key_ff <= key_in;
   end

endmodule

>>> sv/bounded_int_stack_with_search.sv
// Bounded LIFO stack of signed 32-bit words with linear search.
// Input channel req_*: one transaction carries an operation (push, pop, peek, clear,
// search) and a value. Result channel rsp_*: exactly one transaction per input, with
// status, data, found index, count and empty/full flags. csr_wr_en/csr_wr_data set the
// capacity in use (values above DEPTH act as DEPTH); write it only while idle.
// Push, clear, refusals and unknown operations load their result straight from the
// accept; a pop or peek that hits first reads the top entry (S_READ), and a search
// walks from the top entry down in S_SCAN until a match or a miss at the bottom entry.
// Pop, peek and search wait on the single registered read port of the entry memory and
// the one comparator, which the search walk visits one entry per cycle.
// One transaction is in flight at a time; req_stall is high while it is at work and
// while a finished result is held by a stalled receiver. The result sits in an output
// register and holds steady while rsp_stall is high.
// Synchronous reset empties the stack, drops any pending result and sets the capacity
// to 64; memory contents are not cleared, only entries below the count are ever read.
// depends on bis_pkg, bis_ram, bis_seq and bounded_int_stack_with_search_macros.svh
`timescale 1ns / 1ps
`include "bounded_int_stack_with_search_macros.svh"

module bounded_int_stack_with_search #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bis_pkg::bis_req_type        req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bis_pkg::bis_rsp_type        rsp_item,
   input  logic                        csr_wr_en,
   input  logic [bis_pkg::CAP_W-1:0]   csr_wr_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [bis_pkg::CAP_W-1:0]  capacity_ff;
   logic                       rsp_valid_ff;
   bis_pkg::bis_rsp_type       rsp_ff;
   logic                       seq_idle;
   logic                       res_load;
   bis_pkg::bis_rsp_type       res_item;
   logic                       req_accept;
   logic                       wr_en, rd_en;
   logic [AW-1:0]              wr_addr, rd_addr;
   logic [bis_pkg::WORD_W-1:0] wr_data, rd_data;

   // take a transaction only when the output slot is free by the next edge
   assign req_stall  = !seq_idle || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   bis_seq #(
      .DEPTH(DEPTH),
      .AW   (AW),
      .CW   (CW)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_take (req_accept),
      .req_item (req_item),
      .capacity (capacity_ff),
      .seq_idle (seq_idle),
      .res_load (res_load),
      .res_item (res_item),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   bis_ram #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= bis_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (res_load) begin
         rsp_ff <= res_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `BIS_ASSERT_NOW(a_no_overwrite, res_load, !(rsp_valid_ff && rsp_stall), "result overwrote a held transaction")
   `BIS_ASSERT_NEXT(a_accept_progress, req_accept, rsp_valid_ff || !seq_idle, "accepted transaction left no trace")
   `BIS_ASSERT_NOW(a_full_flag, rsp_valid_ff && (rsp_ff.status == bis_pkg::ST_FULL), rsp_ff.is_full, "refused push without full flag")

endmodule

>>> sim/testbench.sv
// self-checking testbench for bounded_int_stack_with_search: directed table, then random phases
// depends on bis_pkg and the bounded_int_stack_with_search top level
`timescale 1ns / 1ps

module testbench;

   localparam int STACK_DEPTH = 64;
   localparam int NUM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 80;
   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 80;
   localparam int STALL_LIMIT = 4000;

   // operation codes the block does not define
   localparam logic [bis_pkg::OP_W-1:0] OP_SPARE_A = 3'd5;
   localparam logic [bis_pkg::OP_W-1:0] OP_SPARE_B = 3'd6;
   localparam logic [bis_pkg::OP_W-1:0] OP_SPARE_C = 3'd7;

   typedef struct {
      bit                            is_csr;
      logic [bis_pkg::CAP_W-1:0]     cap;
      logic [bis_pkg::OP_W-1:0]      op;
      logic [bis_pkg::WORD_W-1:0]    value;
      bit                            typed;
      bis_pkg::bis_rsp_type          rsp;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   bis_pkg::bis_req_type req_item;
   logic        rsp_valid;
   logic        rsp_stall;
   bis_pkg::bis_rsp_type rsp_item;
   logic        csr_wr_en;
   logic [bis_pkg::CAP_W-1:0] csr_wr_data;

   // predictor state
   logic signed [bis_pkg::WORD_W-1:0] stack_words [0:STACK_DEPTH-1];
   int               stack_depth;
   logic [bis_pkg::CAP_W-1:0] cap_setting;

   bis_pkg::bis_rsp_type expected_results [$];
   stim_row_type directed_rows [$];
   int          mismatch_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          long_hold_request;
   int          quiet_cycles;

   bounded_int_stack_with_search #(.DEPTH(STACK_DEPTH)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bis_pkg::bis_rsp_type apply_stack_op(bis_pkg::bis_req_type item);
      bis_pkg::bis_rsp_type r;
      int cap_now;
      int idx;
      bit hit;
      r = '0;
      hit = 1'b0;
      cap_now = (cap_setting > STACK_DEPTH) ? STACK_DEPTH : int'(cap_setting);
      case (item.operation)
         bis_pkg::OP_PUSH: begin
            if (stack_depth >= cap_now) begin
               r.status = bis_pkg::ST_FULL;
            end else begin
               stack_words[stack_depth] = item.value;
               stack_depth++;
            end
         end
         bis_pkg::OP_POP, bis_pkg::OP_PEEK: begin
            if (stack_depth == 0) begin
               r.status = bis_pkg::ST_EMPTY;
            end else begin
               r.data = stack_words[stack_depth-1];
               if (item.operation == bis_pkg::OP_POP) stack_depth--;
            end
         end
         bis_pkg::OP_CLEAR: begin
            stack_depth = 0;
         end
         bis_pkg::OP_SEARCH: begin
            // nearest match from the top wins
            idx = stack_depth - 1;
            while (idx >= 0 && !hit) begin
               if (stack_words[idx] == item.value) begin
                  hit = 1'b1;
                  r.found_index = 6'(idx);
               end
               idx--;
            end
            if (!hit) r.status = bis_pkg::ST_NOTFOUND;
         end
         default: begin
         end
      endcase
      r.count = 7'(stack_depth);
      r.is_empty = (stack_depth == 0);
      r.is_full = (stack_depth >= cap_now);
      return r;
   endfunction

   function automatic logic [bis_pkg::OP_W-1:0] choose_op(int push_pct);
      int r;
      r = $urandom_range(99);
      if (r < push_pct) return bis_pkg::OP_PUSH;
      r = $urandom_range(99);
      if (r < 30) return bis_pkg::OP_POP;
      if (r < 45) return bis_pkg::OP_PEEK;
      if (r < 82) return bis_pkg::OP_SEARCH;
      if (r < 86) return bis_pkg::OP_CLEAR;
      return 3'($urandom_range(OP_SPARE_C, OP_SPARE_A));
   endfunction

   function automatic logic [bis_pkg::WORD_W-1:0] pick_value(bit for_search);
      int r;
      r = $urandom_range(99);
      // search keys mostly taken from what the stack holds
      if (for_search && stack_depth > 0 && r < 55)
         return stack_words[$urandom_range(stack_depth-1)];
      r = $urandom_range(99);
      if (r < 15) return 32'($urandom_range(7));
      if (r < 22) begin
         case ($urandom_range(3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom;
   endfunction

   task automatic report_mismatch(string what, logic [bis_pkg::WORD_W-1:0] want,
                                  logic [bis_pkg::WORD_W-1:0] got);
      $display("mismatch at %0t in %s: expected %h, got %h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   task automatic add_op(logic [bis_pkg::OP_W-1:0] op, logic [bis_pkg::WORD_W-1:0] value);
      stim_row_type row;
      row = '{default: '0};
      row.op = op;
      row.value = value;
      directed_rows.push_back(row);
   endtask

   task automatic add_typed(logic [bis_pkg::OP_W-1:0] op, logic [bis_pkg::WORD_W-1:0] value,
                            logic [bis_pkg::STAT_W-1:0] status,
                            logic [bis_pkg::WORD_W-1:0] data,
                            logic [bis_pkg::FIDX_W-1:0] found,
                            logic [bis_pkg::CNT_O_W-1:0] count,
                            logic empty, logic full);
      stim_row_type row;
      row = '{default: '0};
      row.op = op;
      row.value = value;
      row.typed = 1'b1;
      row.rsp.status = status;
      row.rsp.data = data;
      row.rsp.found_index = found;
      row.rsp.count = count;
      row.rsp.is_empty = empty;
      row.rsp.is_full = full;
      directed_rows.push_back(row);
   endtask

   task automatic add_cap(logic [bis_pkg::CAP_W-1:0] cap);
      stim_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.cap = cap;
      directed_rows.push_back(row);
   endtask

   // offer one transaction, record its expected result once accepted
   task automatic send_item(bis_pkg::bis_req_type item, bit typed,
                            bis_pkg::bis_rsp_type typed_rsp);
      bis_pkg::bis_rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_stack_op(item);
      expected_results.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(logic [bis_pkg::CAP_W-1:0] cap);
      wait_until_drained();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cap_setting = cap;
   endtask

   // receiver: random stall, or one long hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      bis_pkg::bis_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_item.data);
         end else begin
            want = expected_results.pop_front();
            if (rsp_item.status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_item.status));
            if (rsp_item.data !== want.data)
               report_mismatch("data", want.data, rsp_item.data);
            if (rsp_item.found_index !== want.found_index)
               report_mismatch("found_index", 32'(want.found_index),
                               32'(rsp_item.found_index));
            if (rsp_item.count !== want.count)
               report_mismatch("count", 32'(want.count), 32'(rsp_item.count));
            if (rsp_item.is_empty !== want.is_empty)
               report_mismatch("is_empty", 32'(want.is_empty), 32'(rsp_item.is_empty));
            if (rsp_item.is_full !== want.is_full)
               report_mismatch("is_full", 32'(want.is_full), 32'(rsp_item.is_full));
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int phase;
      int n;
      int push_pct [NUM_PHASES];
      logic [bis_pkg::CAP_W-1:0] phase_cap [NUM_PHASES];
      bis_pkg::bis_req_type item;
      bis_pkg::bis_rsp_type no_rsp;
      stim_row_type row;

      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stack_depth = 0;
      cap_setting = bis_pkg::CAP_RESET;
      no_rsp = '0;
      push_pct = '{75, 50, 60, 40, 50, 45};
      phase_cap = '{7'd64, 7'd3, 7'd127, 7'd0, 7'd0, 7'd1};

      // empty stack, extremes, duplicates, unknown codes
      add_typed(bis_pkg::OP_POP, 32'h0, bis_pkg::ST_EMPTY, 32'h0, 6'd0, 7'd0, 1'b1, 1'b0);
      add_typed(bis_pkg::OP_PEEK, 32'h0, bis_pkg::ST_EMPTY, 32'h0, 6'd0, 7'd0, 1'b1, 1'b0);
      add_typed(bis_pkg::OP_SEARCH, 32'h0, bis_pkg::ST_NOTFOUND, 32'h0, 6'd0, 7'd0, 1'b1, 1'b0);
      add_typed(bis_pkg::OP_PUSH, 32'h7fff_ffff, bis_pkg::ST_OK, 32'h0, 6'd0, 7'd1, 1'b0, 1'b0);
      add_typed(bis_pkg::OP_PUSH, 32'h8000_0000, bis_pkg::ST_OK, 32'h0, 6'd0, 7'd2, 1'b0, 1'b0);
      add_typed(bis_pkg::OP_PUSH, 32'h0, bis_pkg::ST_OK, 32'h0, 6'd0, 7'd3, 1'b0, 1'b0);
      add_typed(bis_pkg::OP_PUSH, 32'hffff_ffff, bis_pkg::ST_OK, 32'h0, 6'd0, 7'd4, 1'b0, 1'b0);
      add_typed(bis_pkg::OP_SEARCH, 32'h7fff_ffff, bis_pkg::ST_OK, 32'h0, 6'd0, 7'd4, 1'b0, 1'b0);
      add_typed(bis_pkg::OP_SEARCH, 32'hffff_ffff, bis_pkg::ST_OK, 32'h0, 6'd3, 7'd4, 1'b0, 1'b0);
      add_typed(bis_pkg::OP_SEARCH, 32'd12345, bis_pkg::ST_NOTFOUND,
                32'h0, 6'd0, 7'd4, 1'b0, 1'b0);
      add_typed(bis_pkg::OP_PUSH, 32'h7fff_ffff, bis_pkg::ST_OK, 32'h0, 6'd0, 7'd5, 1'b0, 1'b0);
      add_typed(bis_pkg::OP_SEARCH, 32'h7fff_ffff, bis_pkg::ST_OK, 32'h0, 6'd4, 7'd5, 1'b0, 1'b0);
      add_typed(bis_pkg::OP_PEEK, 32'h0, bis_pkg::ST_OK, 32'h7fff_ffff, 6'd0, 7'd5, 1'b0, 1'b0);
      add_typed(bis_pkg::OP_POP, 32'h0, bis_pkg::ST_OK, 32'h7fff_ffff, 6'd0, 7'd4, 1'b0, 1'b0);
      add_typed(OP_SPARE_A, 32'h1, bis_pkg::ST_OK, 32'h0, 6'd0, 7'd4, 1'b0, 1'b0);
      add_typed(OP_SPARE_C, 32'hffff_ffff, bis_pkg::ST_OK, 32'h0, 6'd0, 7'd4, 1'b0, 1'b0);
      add_op(OP_SPARE_B, 32'h5555_aaaa);
      // capacity lowered below the count
      add_cap(7'd2);
      add_typed(bis_pkg::OP_PUSH, 32'h5, bis_pkg::ST_FULL, 32'h0, 6'd0, 7'd4, 1'b0, 1'b1);
      add_typed(bis_pkg::OP_POP, 32'h0, bis_pkg::ST_OK, 32'hffff_ffff, 6'd0, 7'd3, 1'b0, 1'b1);
      add_typed(bis_pkg::OP_SEARCH, 32'h0, bis_pkg::ST_OK, 32'h0, 6'd2, 7'd3, 1'b0, 1'b1);
      add_op(bis_pkg::OP_SEARCH, 32'h8000_0000);
      add_typed(bis_pkg::OP_CLEAR, 32'h0, bis_pkg::ST_OK, 32'h0, 6'd0, 7'd0, 1'b1, 1'b0);
      // zero capacity is always full
      add_cap(7'd0);
      add_typed(bis_pkg::OP_PUSH, 32'h1, bis_pkg::ST_FULL, 32'h0, 6'd0, 7'd0, 1'b1, 1'b1);
      add_typed(bis_pkg::OP_POP, 32'h0, bis_pkg::ST_EMPTY, 32'h0, 6'd0, 7'd0, 1'b1, 1'b1);
      add_typed(bis_pkg::OP_SEARCH, 32'h1, bis_pkg::ST_NOTFOUND, 32'h0, 6'd0, 7'd0, 1'b1, 1'b1);
      // capacity above the depth
      add_cap(7'd127);
      add_op(bis_pkg::OP_PUSH, 32'd42);
      add_op(bis_pkg::OP_PEEK, 32'h0);
      add_op(bis_pkg::OP_CLEAR, 32'h0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            write_capacity(row.cap);
         end else begin
            item.operation = row.op;
            item.value = row.value;
            send_item(item, row.typed, row.rsp);
         end
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase < 2) begin
            send_idle_pct = 28;
            recv_idle_pct = 67;
         end else if (phase < 4) begin
            send_idle_pct = 67;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_capacity(phase == 4 ? 7'($urandom_range(127)) : phase_cap[phase]);
         // receiver holds off while the sender keeps offering
         if (phase == 4) long_hold_request = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 1 && n == ITEMS_PER_PHASE / 2) wait_until_drained();
            item.operation = choose_op(push_pct[phase]);
            item.value = pick_value(item.operation == bis_pkg::OP_SEARCH);
            send_item(item, 1'b0, no_rsp);
         end
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
